// File: hw/rtl/im2col_pkg.sv
// im2col row address generator: shared types and constants
// holds the beat structs, the configuration register set and its index codes
// no dependencies
package im2col_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;
    localparam int POS_W = 16;
    localparam int IH_W = 19;
    localparam int PROD_W = 26;
    localparam int CNT_W = 7;
    localparam int COL_W = 6;
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_HEIGHT   = 3'd0,
        CFG_SRC_WIDTH    = 3'd1,
        CFG_OUT_WIDTH    = 3'd2,
        CFG_PAD_TOP      = 3'd3,
        CFG_PAD_LEFT     = 3'd4,
        CFG_STRIDE_VERT  = 3'd5,
        CFG_STRIDE_HORIZ = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [12:0] src_height;
        logic [12:0] src_width;
        logic [6:0]  out_width;
        logic [3:0]  pad_top;
        logic [3:0]  pad_left;
        logic [3:0]  stride_vert;
        logic [3:0]  stride_horiz;
    } t_cfg;

    typedef struct packed {
        logic [31:0] plane_base;
        logic [3:0]  kernel_row;
        logic [3:0]  kernel_col;
        logic [11:0] out_row;
    } t_item;

    typedef struct packed {
        logic [5:0]  column_index;
        logic [31:0] source_address;
        logic        is_padding;
        logic        last;
    } t_result;

endpackage

// File: hw/rtl/im2col_fifo.sv
// im2col row address generator: small first-word-fall-through queue
// used between front and back and as the result buffer; no package use
module im2col_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [WIDTH-1:0]             i_wr_data,
    input  logic                         i_rd,
    output logic [WIDTH-1:0]             o_rd_data,
    output logic                         o_full,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_ok;
    logic             rd_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign wr_ok   = i_wr & ~o_full;
    assign rd_ok   = i_rd & ~o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_count <= r_count + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/im2col_front.sv
// im2col row address generator: front end
// takes row beats, finds the source row and its base address, feeds the row queue
// depends on im2col_pkg
module im2col_front #(
    parameter int DIL_VERT  = 1,
    parameter int DIL_HORIZ = 1,
    parameter int ADDR_BITS = 32,
    parameter int DEPTH     = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    input  im2col_pkg::t_item                     i_item,
    input  im2col_pkg::t_cfg                      i_cfg,
    input  logic [$clog2(DEPTH+1)-1:0]            i_mid_count,
    output logic                                  o_full,
    output logic                                  o_mid_wr,
    output logic [ADDR_BITS+im2col_pkg::POS_W:0]  o_mid_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = CNT_W + 1;
    localparam int IH_W = im2col_pkg::IH_W;
    localparam int POS_W = im2col_pkg::POS_W;
    localparam int PROD_W = im2col_pkg::PROD_W;

    logic                 accept;
    logic [OCC_W-1:0]     occ;
    logic [IH_W-1:0]      ih;
    logic                 ih_ok;
    logic [POS_W-1:0]     iw0;
    logic [ADDR_BITS-1:0] rbase;

    logic                 r_s1_v;
    logic [31:0]          r_s1_base;
    logic [12:0]          r_s1_ih;
    logic                 r_s1_ok;
    logic [POS_W-1:0]     r_s1_iw0;

    logic                 r_s2_v;
    logic [31:0]          r_s2_base;
    logic [PROD_W-1:0]    r_s2_prod;
    logic                 r_s2_ok;
    logic [POS_W-1:0]     r_s2_iw0;

    assign occ = OCC_W'(i_mid_count) + OCC_W'(r_s1_v) + OCC_W'(r_s2_v);
    assign o_full = (occ >= OCC_W'(DEPTH));
    assign accept = i_push & ~o_full;

    assign ih = IH_W'(i_item.out_row) * IH_W'(i_cfg.stride_vert)
              + IH_W'(i_item.kernel_row) * IH_W'(DIL_VERT)
              - IH_W'(i_cfg.pad_top);
    assign ih_ok = ~ih[IH_W-1] && (ih[IH_W-2:0] < (IH_W-1)'(i_cfg.src_height));
    assign iw0 = POS_W'(i_item.kernel_col) * POS_W'(DIL_HORIZ) - POS_W'(i_cfg.pad_left);

    assign rbase = r_s2_ok ? ADDR_BITS'(r_s2_base) + ADDR_BITS'(r_s2_prod) : '0;
    assign o_mid_wr = r_s2_v;
    assign o_mid_data = {rbase, r_s2_ok, r_s2_iw0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
        end
    end

    // row payload, no reset
    always_ff @(posedge i_clk) begin
        r_s1_base <= i_item.plane_base;
        r_s1_ih   <= ih[12:0];
        r_s1_ok   <= ih_ok;
        r_s1_iw0  <= iw0;
        r_s2_base <= r_s1_base;
        r_s2_prod <= PROD_W'(r_s1_ih) * PROD_W'(i_cfg.src_width);
        r_s2_ok   <= r_s1_ok;
        r_s2_iw0  <= r_s1_iw0;
    end

endmodule

// File: hw/rtl/im2col_back.sv
// im2col row address generator: back end
// walks the output columns of one queued row, one result beat per cycle
// while the result queue has room; depends on im2col_pkg
module im2col_back #(
    parameter int MAX_OUT_WIDTH = 64,
    parameter int ADDR_BITS     = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  im2col_pkg::t_cfg                      i_cfg,
    input  logic                                  i_mid_empty,
    input  logic [ADDR_BITS+im2col_pkg::POS_W:0]  i_mid_data,
    output logic                                  o_mid_rd,
    input  logic                                  i_out_full,
    output logic                                  o_out_wr,
    output im2col_pkg::t_result                   o_out_data
);

    localparam int POS_W = im2col_pkg::POS_W;
    localparam int CNT_W = im2col_pkg::CNT_W;
    localparam int COL_W = im2col_pkg::COL_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [COL_W-1:0]     r_col;
    logic [COL_W-1:0]     n_col;
    logic [POS_W-1:0]     r_iw;
    logic [POS_W-1:0]     n_iw;
    logic [ADDR_BITS-1:0] r_rbase;
    logic                 r_ih_ok;
    logic                 load;

    logic [CNT_W-1:0]     count;
    logic                 col_ok;
    logic                 is_last;
    logic [ADDR_BITS-1:0] addr;

    assign count = (i_cfg.out_width > CNT_W'(MAX_OUT_WIDTH)) ? CNT_W'(MAX_OUT_WIDTH)
                                                             : i_cfg.out_width;
    assign col_ok = r_ih_ok && ~r_iw[POS_W-1]
                 && (r_iw[POS_W-2:0] < (POS_W-1)'(i_cfg.src_width));
    assign is_last = (CNT_W'(r_col) + CNT_W'(1) == count);
    assign addr = r_rbase + ADDR_BITS'(r_iw[POS_W-2:0]);

    assign o_out_data.column_index   = r_col;
    assign o_out_data.source_address = col_ok ? 32'(addr) : '0;
    assign o_out_data.is_padding     = ~col_ok;
    assign o_out_data.last           = is_last;

    always_comb begin
        n_state  = r_state;
        n_col    = r_col;
        n_iw     = r_iw;
        o_mid_rd = 1'b0;
        o_out_wr = 1'b0;
        load     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_mid_empty) begin
                    o_mid_rd = 1'b1;
                    if (count != '0) begin
                        load    = 1'b1;
                        n_col   = '0;
                        n_iw    = i_mid_data[POS_W-1:0];
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (!i_out_full) begin
                    o_out_wr = 1'b1;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_col = r_col + 1'b1;
                        n_iw  = r_iw + POS_W'(i_cfg.stride_horiz);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_iw    <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_iw    <= n_iw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rbase <= i_mid_data[ADDR_BITS+POS_W:POS_W+1];
            r_ih_ok <= i_mid_data[POS_W];
        end
    end

endmodule

// File: hw/rtl/im2col_row_address_generator.sv
// rows pass front registers s1 and s2 and the row queue to the back end, which takes
// a row only when idle, then one result beat per cycle while the out queue has room
// a row with out_width of zero is dropped and gives no result beat
// reset (synchronous, active low) empties both queues, idles the column walk
// and loads the register reset values; no clearing pass
module im2col_row_address_generator #(
    parameter int MAX_OUT_WIDTH = 64,
    parameter int DIL_VERT      = 1,
    parameter int DIL_HORIZ     = 1,
    parameter int ADDR_BITS     = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  im2col_pkg::t_item                      i_item,
    output logic                                   empty,
    input  logic                                   pop,
    output im2col_pkg::t_result                    o_result,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [im2col_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [im2col_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int MID_W = ADDR_BITS + im2col_pkg::POS_W + 1;
    localparam int MID_DEPTH = im2col_pkg::MID_DEPTH;
    localparam int OUT_DEPTH = im2col_pkg::OUT_DEPTH;
    localparam int RES_W = $bits(im2col_pkg::t_result);

    im2col_pkg::t_cfg                r_cfg;
    logic                            mid_wr;
    logic [MID_W-1:0]                mid_wr_data;
    logic                            mid_rd;
    logic [MID_W-1:0]                mid_rd_data;
    logic                            mid_empty;
    logic                            mid_full;
    logic [$clog2(MID_DEPTH+1)-1:0]  mid_count;
    logic                            out_wr;
    im2col_pkg::t_result             out_wr_data;
    logic [RES_W-1:0]                out_rd_data;
    logic                            out_full;
    logic [$clog2(OUT_DEPTH+1)-1:0]  out_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_height   <= 13'd1;
            r_cfg.src_width    <= 13'd1;
            r_cfg.out_width    <= 7'd1;
            r_cfg.pad_top      <= 4'd0;
            r_cfg.pad_left     <= 4'd0;
            r_cfg.stride_vert  <= 4'd1;
            r_cfg.stride_horiz <= 4'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (im2col_pkg::t_cfg_idx'(i_cfg_index))
                im2col_pkg::CFG_SRC_HEIGHT:   r_cfg.src_height   <= i_cfg_data;
                im2col_pkg::CFG_SRC_WIDTH:    r_cfg.src_width    <= i_cfg_data;
                im2col_pkg::CFG_OUT_WIDTH:    r_cfg.out_width    <= i_cfg_data[6:0];
                im2col_pkg::CFG_PAD_TOP:      r_cfg.pad_top      <= i_cfg_data[3:0];
                im2col_pkg::CFG_PAD_LEFT:     r_cfg.pad_left     <= i_cfg_data[3:0];
                im2col_pkg::CFG_STRIDE_VERT:  r_cfg.stride_vert  <= i_cfg_data[3:0];
                im2col_pkg::CFG_STRIDE_HORIZ: r_cfg.stride_horiz <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    im2col_front #(
        .DIL_VERT  (DIL_VERT),
        .DIL_HORIZ (DIL_HORIZ),
        .ADDR_BITS (ADDR_BITS),
        .DEPTH     (MID_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_cfg       (r_cfg),
        .i_mid_count (mid_count),
        .o_full      (full),
        .o_mid_wr    (mid_wr),
        .o_mid_data  (mid_wr_data)
    );

    im2col_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (mid_wr),
        .i_wr_data (mid_wr_data),
        .i_rd      (mid_rd),
        .o_rd_data (mid_rd_data),
        .o_full    (mid_full),
        .o_empty   (mid_empty),
        .o_count   (mid_count)
    );

    im2col_back #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .ADDR_BITS     (ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_mid_empty (mid_empty),
        .i_mid_data  (mid_rd_data),
        .o_mid_rd    (mid_rd),
        .i_out_full  (out_full),
        .o_out_wr    (out_wr),
        .o_out_data  (out_wr_data)
    );

    im2col_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (out_wr & ~mid_full | out_wr),
        .i_wr_data (out_wr_data),
        .i_rd      (pop),
        .o_rd_data (out_rd_data),
        .o_full    (out_full),
        .o_empty   (empty),
        .o_count   (out_count)
    );

    assign o_result = im2col_pkg::t_result'(out_rd_data);

endmodule

// File: hw/rtl/im2col_chk.sv
// im2col row address generator: port checker and its bind
// watches the top level ports only; depends on im2col_pkg
module im2col_chk #(
    parameter int MAX_OUT_WIDTH = 64
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 full,
    input logic                 empty,
    input logic                 pop,
    input im2col_pkg::t_result  o_result
);

    // queues come out of reset empty
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full right after reset");

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result waiting right after reset");

    // padding beat carries a zero address
    a_pad_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.is_padding |-> o_result.source_address == '0)
        else $error("padding beat with nonzero address");

    // widest row ends on the top column
    a_top_col_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.column_index == im2col_pkg::COL_W'(MAX_OUT_WIDTH - 1)
        |-> o_result.last)
        else $error("top column beat not marked last");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("waiting result beat changed or vanished");

endmodule

bind im2col_row_address_generator im2col_chk #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
) u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

// File: sim/im2col_checker.sv
`timescale 1ns / 100ps
// im2col row address generator checker: watches the register, row and column channels,
// expands each accepted row into its expected column beats and compares them in order
// depends on im2col_pkg
module im2col_checker #(
    parameter int MAX_OUT_WIDTH = 64,
    parameter int DIL_VERT      = 1,
    parameter int DIL_HORIZ     = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic                                i_full,
    input  im2col_pkg::t_item                   i_item,
    input  logic                                i_empty,
    input  logic                                i_pop,
    input  im2col_pkg::t_result                 i_result,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [im2col_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [im2col_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                i_end_check,
    output int                                  o_mismatch_count,
    output int                                  o_outstanding,
    output int                                  o_beats_checked
);

    im2col_pkg::t_cfg    shadow;
    im2col_pkg::t_result column_queue[$];
    int                  mismatch_count;
    int                  beats_checked;
    bit                  end_done;

    assign o_mismatch_count = mismatch_count;
    assign o_beats_checked  = beats_checked;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] mismatch at column beat %0d: %s, expected %0h, got %0h",
                 $realtime, beats_checked, what, want, got);
        mismatch_count++;
    endtask

    // expected column beats of one row under the current register settings
    task automatic expand_row(input im2col_pkg::t_item row);
        longint              ih;
        longint              iw;
        logic [31:0]         row_base;
        int                  n;
        bit                  row_ok;
        bit                  col_ok;
        im2col_pkg::t_result beat;
        n = (shadow.out_width > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : int'(shadow.out_width);
        ih = longint'(row.out_row) * longint'(shadow.stride_vert) - longint'(shadow.pad_top)
             + longint'(row.kernel_row) * DIL_VERT;
        row_ok = (ih >= 0) && (ih < longint'(shadow.src_height));
        row_base = row.plane_base + 32'(ih * longint'(shadow.src_width));
        for (int ow = 0; ow < n; ow++) begin
            iw = longint'(ow) * longint'(shadow.stride_horiz) - longint'(shadow.pad_left)
                 + longint'(row.kernel_col) * DIL_HORIZ;
            col_ok = row_ok && (iw >= 0) && (iw < longint'(shadow.src_width));
            beat.column_index   = 6'(ow);
            beat.source_address = col_ok ? row_base + 32'(iw) : 32'd0;
            beat.is_padding     = !col_ok;
            beat.last           = (ow == n - 1);
            column_queue.push_back(beat);
        end
    endtask

    task automatic check_beat(input im2col_pkg::t_result got);
        im2col_pkg::t_result want;
        if (column_queue.size() == 0) begin
            report_mismatch("beat with nothing expected, address", 32'd0, got.source_address);
        end else begin
            want = column_queue.pop_front();
            if (got.column_index !== want.column_index)
                report_mismatch("column_index", 32'(want.column_index),
                                32'(got.column_index));
            if (got.source_address !== want.source_address)
                report_mismatch("source_address", want.source_address, got.source_address);
            if (got.is_padding !== want.is_padding)
                report_mismatch("is_padding", 32'(want.is_padding), 32'(got.is_padding));
            if (got.last !== want.last)
                report_mismatch("last", 32'(want.last), 32'(got.last));
        end
        beats_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow.src_height   = 13'd1;
            shadow.src_width    = 13'd1;
            shadow.out_width    = 7'd1;
            shadow.pad_top      = 4'd0;
            shadow.pad_left     = 4'd0;
            shadow.stride_vert  = 4'd1;
            shadow.stride_horiz = 4'd1;
            column_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (im2col_pkg::t_cfg_idx'(i_cfg_index))
                    im2col_pkg::CFG_SRC_HEIGHT:   shadow.src_height   = i_cfg_data;
                    im2col_pkg::CFG_SRC_WIDTH:    shadow.src_width    = i_cfg_data;
                    im2col_pkg::CFG_OUT_WIDTH:    shadow.out_width    = i_cfg_data[6:0];
                    im2col_pkg::CFG_PAD_TOP:      shadow.pad_top      = i_cfg_data[3:0];
                    im2col_pkg::CFG_PAD_LEFT:     shadow.pad_left     = i_cfg_data[3:0];
                    im2col_pkg::CFG_STRIDE_VERT:  shadow.stride_vert  = i_cfg_data[3:0];
                    im2col_pkg::CFG_STRIDE_HORIZ: shadow.stride_horiz = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // a beat leaving now cannot belong to a row entering on the same edge
            if (i_pop && !i_empty)
                check_beat(i_result);
            if (i_push && !i_full)
                expand_row(i_item);
            if (i_end_check && !end_done) begin
                end_done = 1;
                while (column_queue.size() != 0) begin
                    report_mismatch("missing beat, column",
                                    32'(column_queue[0].column_index), 32'd0);
                    void'(column_queue.pop_front());
                end
            end
        end
        o_outstanding = column_queue.size();
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// im2col row address generator testbench top: clock, reset, register programming,
// row stimulus and column beat draining with random idling, watchdog and verdict
// depends on im2col_pkg, im2col_checker and the generator itself
module tb_top;

    localparam int MAX_OUT_WIDTH  = 64;
    localparam int DIL_VERT       = 1;
    localparam int DIL_HORIZ      = 1;
    localparam int ADDR_BITS      = 32;
    localparam int ROW_TARGET     = 350;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [im2col_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    logic                              clk;
    logic                              rst_n;
    logic                              push;
    logic                              full;
    im2col_pkg::t_item                 row_beat;
    logic                              empty;
    logic                              pop;
    im2col_pkg::t_result               column_beat;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [im2col_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [im2col_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                              end_check;

    int mismatch_count;
    int outstanding;
    int beats_checked;
    int rows_sent;
    int settings_used;
    bit idle_on;

    // effective register values, used to aim rows at the image
    int height_eff;
    int pad_top_eff;
    int stride_vert_eff;
    int out_width_eff;

    im2col_row_address_generator #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .DIL_VERT      (DIL_VERT),
        .DIL_HORIZ     (DIL_HORIZ),
        .ADDR_BITS     (ADDR_BITS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .push        (push),
        .full        (full),
        .i_item      (row_beat),
        .empty       (empty),
        .pop         (pop),
        .o_result    (column_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    im2col_checker #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .DIL_VERT      (DIL_VERT),
        .DIL_HORIZ     (DIL_HORIZ)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_item           (row_beat),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_result         (column_beat),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_end_check      (end_check),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding),
        .o_beats_checked  (beats_checked)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int idle_draw();
        if (!idle_on)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    function automatic im2col_pkg::t_item row_of(input logic [31:0] base,
                                                 input logic [3:0] kh,
                                                 input logic [3:0] kw,
                                                 input logic [11:0] oh);
        im2col_pkg::t_item r;
        r.plane_base = base;
        r.kernel_row = kh;
        r.kernel_col = kw;
        r.out_row    = oh;
        return r;
    endfunction

    // mostly rows that land on the image, some anywhere
    function automatic im2col_pkg::t_item make_row();
        logic [31:0] base;
        int          oh_max;
        int          oh;
        base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 4095)
                                           : $urandom;
        oh_max = (height_eff + pad_top_eff) / ((stride_vert_eff == 0) ? 1 : stride_vert_eff) + 1;
        if (oh_max > 4095)
            oh_max = 4095;
        oh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, oh_max);
        return row_of(base, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 12'(oh));
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic write_reg(input logic [im2col_pkg::CFG_IDX_W-1:0] idx,
                             input logic [im2col_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        forever begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [12:0] h, input logic [12:0] w, input logic [12:0] ow,
                                input logic [12:0] pt, input logic [12:0] pl,
                                input logic [12:0] sv, input logic [12:0] sh,
                                input bit poke_unused);
        write_reg(im2col_pkg::CFG_SRC_HEIGHT, h);
        write_reg(im2col_pkg::CFG_SRC_WIDTH, w);
        write_reg(im2col_pkg::CFG_OUT_WIDTH, ow);
        write_reg(im2col_pkg::CFG_PAD_TOP, pt);
        write_reg(im2col_pkg::CFG_PAD_LEFT, pl);
        write_reg(im2col_pkg::CFG_STRIDE_VERT, sv);
        write_reg(im2col_pkg::CFG_STRIDE_HORIZ, sh);
        if (poke_unused)
            write_reg(CFG_UNUSED_IDX, 13'($urandom));
        cfg_valid       <= 1'b0;
        height_eff      = int'(h);
        pad_top_eff     = int'(pt[3:0]);
        stride_vert_eff = int'(sv[3:0]);
        out_width_eff   = int'(ow[6:0]);
        settings_used++;
    endtask

    task automatic send_row(input im2col_pkg::t_item r);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push     <= 1'b1;
        row_beat <= r;
        forever begin
            @(posedge clk);
            if (!full)
                break;
        end
        @(negedge clk);
        if (out_width_eff != 0)
            rows_sent++;
    endtask

    // rows with no column beats may still be in flight when nothing is expected
    task automatic wait_drained();
        push <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // column beat sink
    initial begin
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            gap = idle_draw();
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            forever begin
                @(posedge clk);
                if (!empty)
                    break;
            end
            @(negedge clk);
        end
    end

    // watchdog on cycles with no beat moving on any channel
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        int          pick;
        int          n_rows;
        logic [12:0] h, w, ow, pt, pl, sv, sh;
        rst_n           = 1'b0;
        push            = 1'b0;
        row_beat        = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        end_check       = 1'b0;
        rows_sent       = 0;
        settings_used   = 0;
        idle_on         = 1'b1;
        height_eff      = 1;
        pad_top_eff     = 0;
        stride_vert_eff = 1;
        out_width_eff   = 1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register values out of reset
        send_row(row_of(32'h0000_0000, 4'd0, 4'd0, 12'd0));
        send_row(row_of(32'hFFFF_FFFF, 4'd0, 4'd0, 12'd0));
        wait_drained();

        // 4096 by 4096 image, widest row, widest padding, strides of 8
        program_regs(13'd4096, 13'd4096, 13'd64, 13'd15, 13'd15, 13'd8, 13'd8, 0);
        send_row(row_of(32'hFFFF_FFFF, 4'd15, 4'd15, 12'd4095));
        send_row(row_of(32'hFFFF_FFFF, 4'd15, 4'd15, 12'd0));
        send_row(row_of(32'h0000_0000, 4'd0, 4'd0, 12'd0));
        send_row(row_of(32'hFFFF_0000, 4'd15, 4'd0, 12'd511));
        send_row(row_of(32'h1234_5678, 4'd4, 4'd7, 12'd1));
        wait_drained();

        // zero columns: rows are dropped
        program_regs(13'd16, 13'd16, 13'd0, 13'd1, 13'd1, 13'd1, 13'd1, 0);
        send_row(row_of(32'hA5A5_A5A5, 4'd3, 4'd3, 12'd2));
        send_row(row_of(32'h5A5A_5A5A, 4'd15, 4'd15, 12'd4095));
        wait_drained();

        // zero strides repeat one position, column count above the maximum saturates
        program_regs(13'd8191, 13'd8191, 13'd100, 13'd0, 13'd0, 13'd0, 13'd0, 1);
        send_row(row_of(32'hFFFF_FFFF, 4'd15, 4'd15, 12'd4095));
        send_row(row_of(32'h8000_0000, 4'd0, 4'd9, 12'd0));
        send_row(row_of(32'h0000_0001, 4'd7, 4'd0, 12'd17));
        wait_drained();

        // empty image: every position is padding
        program_regs(13'd0, 13'd0, 13'd127, 13'd0, 13'd0, 13'd15, 13'd15, 0);
        send_row(row_of(32'h0000_0000, 4'd0, 4'd0, 12'd0));
        send_row(row_of(32'hDEAD_BEEF, 4'd15, 4'd15, 12'd4095));
        wait_drained();

        // single element image with the raw data bits set above each field
        program_regs(13'd1, 13'd1, 13'h1F81, 13'h1FF0, 13'h1FF1, 13'h1FF1, 13'h1FF1, 0);
        send_row(row_of(32'h0000_0100, 4'd0, 4'd0, 12'd0));
        send_row(row_of(32'h0000_0100, 4'd0, 4'd1, 12'd0));
        send_row(row_of(32'h0000_0100, 4'd1, 4'd1, 12'd0));
        wait_drained();

        // random register settings, each followed by a burst of rows
        while (rows_sent < ROW_TARGET) begin
            pick = $urandom_range(0, 9);
            h  = 13'($urandom_range(1, 64));
            w  = 13'($urandom_range(1, 64));
            ow = 13'($urandom_range(1, 16));
            pt = 13'($urandom_range(0, 15));
            pl = 13'($urandom_range(0, 15));
            sv = 13'($urandom_range(1, 8));
            sh = 13'($urandom_range(1, 8));
            case (pick)
                0: begin
                    h  = 13'($urandom);
                    w  = 13'($urandom);
                    ow = 13'($urandom);
                    pt = 13'($urandom);
                    pl = 13'($urandom);
                    sv = 13'($urandom);
                    sh = 13'($urandom);
                end
                1: ow = 13'd64;
                2: ow = ($urandom_range(0, 1) == 0) ? 13'd0 : 13'($urandom_range(65, 127));
                3: begin
                    sv = 13'($urandom_range(0, 15));
                    sh = 13'($urandom_range(0, 15));
                end
                4: begin
                    h = 13'($urandom_range(0, 8191));
                    w = 13'($urandom_range(0, 8191));
                end
                default: ;
            endcase
            program_regs(h, w, ow, pt, pl, sv, sh, $urandom_range(0, 7) == 0);
            idle_on = ($urandom_range(0, 3) != 0);
            n_rows  = (out_width_eff == 0) ? 4 : 25;
            for (int k = 0; k < n_rows; k++) begin
                // hold off the rows until every column beat is out
                if (k == 12 && (settings_used == 7 || $urandom_range(0, 3) == 0)) begin
                    push <= 1'b0;
                    while (outstanding != 0)
                        @(negedge clk);
                end
                send_row(make_row());
            end
            wait_drained();
        end

        end_check <= 1'b1;
        @(negedge clk);
        @(negedge clk);
        $display("covered %0d rows under %0d register settings, %0d column beats compared",
                 rows_sent, settings_used, beats_checked);
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
